// File: rtl/ggcd_pkg.sv
// ggcd_pkg: shared constants, codes and defaults of the gaze gesture command detector
// no dependencies; used by the interfaces, the top level and the bench
package ggcd_pkg;

  // frame geometry defaults
  localparam int FRAME_WIDTH_DEF  = 640;
  localparam int FRAME_HEIGHT_DEF = 480;

  // pupil margins around the centre
  localparam int MARGIN_X = 5;
  localparam int MARGIN_Y = 3;

  // closed-eye toggle needs dwell plus this many frames
  localparam int TOGGLE_EXTRA = 10;

  // packed word weights
  localparam int PACK_X = 10000;
  localparam int PACK_Y = 10;

  // input and config field widths
  localparam int PUPIL_W  = 10;
  localparam int GAZE_W   = 16;
  localparam int CX_W     = 10;
  localparam int CY_W     = 9;
  localparam int FRAMES_W = 8;
  localparam int CLOSED_W = 9;
  localparam int CMD_W    = 3;

  // config port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y     = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_DWELL_FRAMES = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_VOTE_FRAMES  = CFG_INDEX_W'(3);

  // register reset values
  localparam logic [CX_W-1:0]     CENTER_X_RST = CX_W'(320);
  localparam logic [CY_W-1:0]     CENTER_Y_RST = CY_W'(240);
  localparam logic [FRAMES_W-1:0] DWELL_RST    = FRAMES_W'(30);
  localparam logic [FRAMES_W-1:0] VOTE_RST     = FRAMES_W'(10);

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE       = 3'd0,
    CMD_ON         = 3'd1,
    CMD_OFF        = 3'd2,
    CMD_UP_LEFT    = 3'd3,
    CMD_UP_RIGHT   = 3'd4,
    CMD_DOWN_LEFT  = 3'd5,
    CMD_DOWN_RIGHT = 3'd6
  } cmd_t;

endpackage

// File: rtl/ggcd_frame_if.sv
// ggcd_frame_if: valid/ready channel carrying one camera frame word
// depends on ggcd_pkg for field widths
interface ggcd_frame_if;
  logic                                valid;
  logic                                ready;
  logic                                eye_open;
  logic [ggcd_pkg::PUPIL_W-1:0]        pupil_x;
  logic [ggcd_pkg::PUPIL_W-1:0]        pupil_y;
  logic signed [ggcd_pkg::GAZE_W-1:0]  gaze_x;
  logic signed [ggcd_pkg::GAZE_W-1:0]  gaze_y;

  modport source (output valid, eye_open, pupil_x, pupil_y, gaze_x, gaze_y, input ready);
  modport sink   (input valid, eye_open, pupil_x, pupil_y, gaze_x, gaze_y, output ready);
endinterface

// File: rtl/ggcd_result_if.sv
// ggcd_result_if: valid/ready channel carrying one result word
// depends on ggcd_pkg for the command width, frame size defaults and pack weights
interface ggcd_result_if #(
  parameter int FRAME_WIDTH  = ggcd_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = ggcd_pkg::FRAME_HEIGHT_DEF
);
  localparam int XW = $clog2(FRAME_WIDTH);
  localparam int YW = $clog2(FRAME_HEIGHT);
  localparam int PW = $clog2((FRAME_WIDTH - 1) * ggcd_pkg::PACK_X
                             + (FRAME_HEIGHT - 1) * ggcd_pkg::PACK_Y + 7);

  logic                         valid;
  logic                         ready;
  logic [XW-1:0]                out_x;
  logic [YW-1:0]                out_y;
  logic [ggcd_pkg::CMD_W-1:0]   command;
  logic [PW-1:0]                packed_word;

  modport source (output valid, out_x, out_y, command, packed_word, input ready);
  modport sink   (input valid, out_x, out_y, command, packed_word, output ready);
endinterface

// File: rtl/gaze_gesture_command_detector_top.sv
// gaze_gesture_command_detector_top: closed-eye toggle, corner gesture voting, gaze packing
// depends on ggcd_pkg, ggcd_frame_if and ggcd_result_if
//
//   channel  dir  handshake      payload
//   frame    in   valid/ready    eye_open, pupil_x, pupil_y, gaze_x, gaze_y
//   result   out  valid/ready    out_x, out_y, command, packed_word
//   wr       in   wr_en only     wr_index, wr_data (no read-back)
//
// one frame per cycle sustained while results are taken; a frame is held in the input register,
// then all counter updates and the packed word are formed in a single pass
// into the result register, which holds an open frame's result word until the receiver takes it
// closed frames update state and produce no result word; the input register doubles as skid:
// while a result waits, a frame is taken if that register is empty or holds a closed frame
// reset (rst, synchronous) clears counters, control, pending command and both valid flags, and
// loads the register defaults
module gaze_gesture_command_detector_top #(
  parameter int FRAME_WIDTH  = ggcd_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = ggcd_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [ggcd_pkg::CFG_INDEX_W-1:0]   wr_index,
  input  logic [ggcd_pkg::CFG_DATA_W-1:0]    wr_data,
  ggcd_frame_if.sink                         frame,
  ggcd_result_if.source                      result
);

  localparam int XW = $clog2(FRAME_WIDTH);
  localparam int YW = $clog2(FRAME_HEIGHT);
  localparam int PW = $clog2((FRAME_WIDTH - 1) * ggcd_pkg::PACK_X
                             + (FRAME_HEIGHT - 1) * ggcd_pkg::PACK_Y + 7);
  localparam int FW = ggcd_pkg::FRAMES_W;
  localparam int CW = ggcd_pkg::CLOSED_W;

  // clamp limits as signed gaze values
  localparam logic signed [ggcd_pkg::GAZE_W-1:0] X_MAX = ggcd_pkg::GAZE_W'(FRAME_WIDTH - 1);
  localparam logic signed [ggcd_pkg::GAZE_W-1:0] Y_MAX = ggcd_pkg::GAZE_W'(FRAME_HEIGHT - 1);
  localparam logic [CW-1:0] CLOSED_MAX = {CW{1'b1}};

  function automatic logic [FW-1:0] sat_inc(input logic [FW-1:0] v);
    return (v == {FW{1'b1}}) ? v : v + FW'(1);
  endfunction

  // configuration registers
  logic [ggcd_pkg::CX_W-1:0] center_x;
  logic [ggcd_pkg::CY_W-1:0] center_y;
  logic [FW-1:0]             dwell_frames;
  logic [FW-1:0]             vote_frames;

  // detector state
  logic [CW-1:0]        closed_count, closed_count_next;
  logic                 control_on, control_on_next;
  logic [FW-1:0]        left_tally, left_tally_next;
  logic [FW-1:0]        right_tally, right_tally_next;
  logic [FW-1:0]        up_tally, up_tally_next;
  logic [FW-1:0]        down_tally, down_tally_next;
  logic [FW-1:0]        keep_count, keep_count_next;
  ggcd_pkg::cmd_t       pending_command, pending_command_next;

  // input register (skid stage)
  logic                                a_valid;
  logic                                a_open;
  logic [ggcd_pkg::PUPIL_W-1:0]        a_px;
  logic [ggcd_pkg::PUPIL_W-1:0]        a_py;
  logic signed [ggcd_pkg::GAZE_W-1:0]  a_gx;
  logic signed [ggcd_pkg::GAZE_W-1:0]  a_gy;

  // result register
  logic                  r_valid;
  logic [XW-1:0]         r_x;
  logic [YW-1:0]         r_y;
  ggcd_pkg::cmd_t        r_cmd;
  logic [PW-1:0]         r_packed;

  logic          out_free;
  logic          a_fire;
  logic [CW-1:0] closed_step;
  logic [CW-1:0] toggle_at;
  logic          left_hit, right_hit, up_hit, down_hit;
  logic          l_vote, r_vote, u_vote, d_vote;
  ggcd_pkg::cmd_t res_cmd;
  logic [XW-1:0] ox;
  logic [YW-1:0] oy;
  logic [PW-1:0] packed_next;

  // closed frames never need the result register
  assign out_free    = !r_valid || result.ready;
  assign a_fire      = a_valid && (!a_open || out_free);
  assign frame.ready = !a_valid || a_fire;

  assign toggle_at = CW'(dwell_frames) + CW'(ggcd_pkg::TOGGLE_EXTRA);

  // pupil position against the centre with margins, in 11 bits so nothing wraps
  assign left_hit  = ({1'b0, a_px} + 11'(ggcd_pkg::MARGIN_X)) < 11'(center_x);
  assign right_hit = {1'b0, a_px} > (11'(center_x) + 11'(ggcd_pkg::MARGIN_X));
  assign up_hit    = ({1'b0, a_py} + 11'(ggcd_pkg::MARGIN_Y)) < 11'(center_y);
  assign down_hit  = {1'b0, a_py} > (11'(center_y) + 11'(ggcd_pkg::MARGIN_Y));

  always_comb begin
    closed_count_next    = closed_count;
    control_on_next      = control_on;
    left_tally_next      = left_tally;
    right_tally_next     = right_tally;
    up_tally_next        = up_tally;
    down_tally_next      = down_tally;
    keep_count_next      = keep_count;
    pending_command_next = pending_command;
    res_cmd              = ggcd_pkg::CMD_NONE;
    l_vote               = 1'b0;
    r_vote               = 1'b0;
    u_vote               = 1'b0;
    d_vote               = 1'b0;
    closed_step          = a_open ? '0
                         : ((closed_count == CLOSED_MAX) ? closed_count
                                                         : closed_count + CW'(1));
    if (a_fire) begin
      closed_count_next = closed_step;
      // an open frame zeroes the count, so a toggle only follows a closed frame
      if (closed_step == toggle_at) begin
        closed_count_next = '0;
        if (!control_on) begin
          control_on_next      = 1'b1;
          pending_command_next = ggcd_pkg::CMD_ON;
        end else begin
          control_on_next      = 1'b0;
          left_tally_next      = '0;
          right_tally_next     = '0;
          up_tally_next        = '0;
          down_tally_next      = '0;
          keep_count_next      = '0;
          pending_command_next = ggcd_pkg::CMD_OFF;
        end
      end
      if (a_open) begin
        if (control_on) begin
          if (left_hit)  left_tally_next  = sat_inc(left_tally);
          if (right_hit) right_tally_next = sat_inc(right_tally);
          if (up_hit)    up_tally_next    = sat_inc(up_tally);
          if (down_hit)  down_tally_next  = sat_inc(down_tally);
          keep_count_next = keep_count + FW'(1);
        end
        // votes use the tallies after this frame's increments
        l_vote = left_tally_next  >= vote_frames;
        r_vote = right_tally_next >= vote_frames;
        u_vote = up_tally_next    >= vote_frames;
        d_vote = down_tally_next  >= vote_frames;
        // end of gesture window; the check also fires with control off at zero dwell
        if (keep_count_next == dwell_frames) begin
          if (l_vote && u_vote)      pending_command_next = ggcd_pkg::CMD_UP_LEFT;
          else if (r_vote && u_vote) pending_command_next = ggcd_pkg::CMD_UP_RIGHT;
          else if (l_vote && d_vote) pending_command_next = ggcd_pkg::CMD_DOWN_LEFT;
          else if (r_vote && d_vote) pending_command_next = ggcd_pkg::CMD_DOWN_RIGHT;
          left_tally_next  = '0;
          right_tally_next = '0;
          up_tally_next    = '0;
          down_tally_next  = '0;
          keep_count_next  = '0;
        end
        res_cmd              = pending_command_next;
        pending_command_next = ggcd_pkg::CMD_NONE;
      end
    end
  end

  // gaze clamp: negative or past the frame edge goes to the last column/row
  assign ox = (a_gx[ggcd_pkg::GAZE_W-1] || (a_gx > X_MAX)) ? XW'(FRAME_WIDTH - 1)
                                                          : a_gx[XW-1:0];
  assign oy = (a_gy[ggcd_pkg::GAZE_W-1] || (a_gy > Y_MAX)) ? YW'(FRAME_HEIGHT - 1)
                                                          : a_gy[YW-1:0];

  // constant-weight products, formed in the same pass as the counter updates
  assign packed_next = PW'(ox) * PW'(ggcd_pkg::PACK_X)
                     + PW'(oy) * PW'(ggcd_pkg::PACK_Y)
                     + PW'(res_cmd);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x        <= ggcd_pkg::CENTER_X_RST;
      center_y        <= ggcd_pkg::CENTER_Y_RST;
      dwell_frames    <= ggcd_pkg::DWELL_RST;
      vote_frames     <= ggcd_pkg::VOTE_RST;
      closed_count    <= '0;
      control_on      <= 1'b0;
      left_tally      <= '0;
      right_tally     <= '0;
      up_tally        <= '0;
      down_tally      <= '0;
      keep_count      <= '0;
      pending_command <= ggcd_pkg::CMD_NONE;
      a_valid         <= 1'b0;
      r_valid         <= 1'b0;
    end else begin
      // register writes; indexes past the list are ignored
      if (wr_en) begin
        case (wr_index)
          ggcd_pkg::REG_CENTER_X:     center_x     <= wr_data[ggcd_pkg::CX_W-1:0];
          ggcd_pkg::REG_CENTER_Y:     center_y     <= wr_data[ggcd_pkg::CY_W-1:0];
          ggcd_pkg::REG_DWELL_FRAMES: dwell_frames <= wr_data[FW-1:0];
          ggcd_pkg::REG_VOTE_FRAMES:  vote_frames  <= wr_data[FW-1:0];
          default: ;
        endcase
      end
      closed_count    <= closed_count_next;
      control_on      <= control_on_next;
      left_tally      <= left_tally_next;
      right_tally     <= right_tally_next;
      up_tally        <= up_tally_next;
      down_tally      <= down_tally_next;
      keep_count      <= keep_count_next;
      pending_command <= pending_command_next;
      if (frame.ready) begin
        a_valid <= frame.valid;
      end
      if (a_fire && a_open) begin
        r_valid <= 1'b1;
      end else if (result.ready) begin
        r_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (frame.ready && frame.valid) begin
      a_open <= frame.eye_open;
      a_px   <= frame.pupil_x;
      a_py   <= frame.pupil_y;
      a_gx   <= frame.gaze_x;
      a_gy   <= frame.gaze_y;
    end
    if (a_fire && a_open) begin
      r_x      <= ox;
      r_y      <= oy;
      r_cmd    <= res_cmd;
      r_packed <= packed_next;
    end
  end

  assign result.valid       = r_valid;
  assign result.out_x       = r_x;
  assign result.out_y       = r_y;
  assign result.command     = r_cmd;
  assign result.packed_word = r_packed;

endmodule

// File: verif/gaze_gesture_command_detector_top_tb.sv
// gaze_gesture_command_detector_top_tb: self-checking bench for the gaze gesture command detector
// drives frame words and register writes, predicts every result word and compares it field by field
// depends on ggcd_pkg, ggcd_frame_if, ggcd_result_if and gaze_gesture_command_detector_top
module gaze_gesture_command_detector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // index past the last register, a write there must change nothing
  localparam logic [ggcd_pkg::CFG_INDEX_W-1:0] REG_NONE = ggcd_pkg::CFG_INDEX_W'(15);
  // length of the forced receiver hold-off, long enough to back the block up
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic                          eye_open;
    logic [ggcd_pkg::PUPIL_W-1:0]  pupil_x;
    logic [ggcd_pkg::PUPIL_W-1:0]  pupil_y;
    logic [ggcd_pkg::GAZE_W-1:0]   gaze_x;
    logic [ggcd_pkg::GAZE_W-1:0]   gaze_y;
  } frame_t;

  typedef struct packed {
    logic [9:0]                 out_x;
    logic [8:0]                 out_y;
    logic [ggcd_pkg::CMD_W-1:0] command;
    logic [22:0]                packed_word;
  } result_t;

  // scoreboard: gesture predictor plus the queue of result words still owed by the block
  class gaze_command_scoreboard;
    logic [ggcd_pkg::CX_W-1:0]     center_x;
    logic [ggcd_pkg::CY_W-1:0]     center_y;
    logic [ggcd_pkg::FRAMES_W-1:0] dwell;
    logic [ggcd_pkg::FRAMES_W-1:0] vote;
    logic [ggcd_pkg::CLOSED_W-1:0] closed_cnt;
    bit                            ctrl_on;
    logic [7:0]                    left_t, right_t, up_t, down_t, keep;
    ggcd_pkg::cmd_t                pending;
    result_t                       expected_words[$];
    int                            errors;

    function new();
      center_x   = ggcd_pkg::CENTER_X_RST;
      center_y   = ggcd_pkg::CENTER_Y_RST;
      dwell      = ggcd_pkg::DWELL_RST;
      vote       = ggcd_pkg::VOTE_RST;
      closed_cnt = '0;
      ctrl_on    = 1'b0;
      clear_window();
      pending    = ggcd_pkg::CMD_NONE;
      errors     = 0;
    endfunction

    function void clear_window();
      left_t  = '0;
      right_t = '0;
      up_t    = '0;
      down_t  = '0;
      keep    = '0;
    endfunction

    function logic [7:0] bump(logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function void set_reg(logic [ggcd_pkg::CFG_INDEX_W-1:0] idx,
                          logic [ggcd_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        ggcd_pkg::REG_CENTER_X:     center_x = data[ggcd_pkg::CX_W-1:0];
        ggcd_pkg::REG_CENTER_Y:     center_y = data[ggcd_pkg::CY_W-1:0];
        ggcd_pkg::REG_DWELL_FRAMES: dwell    = data[ggcd_pkg::FRAMES_W-1:0];
        ggcd_pkg::REG_VOTE_FRAMES:  vote     = data[ggcd_pkg::FRAMES_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_frame(frame_t f);
      int      px, py, cx, cy, gx, gy, ox, oy;
      bit      l, r, u, d;
      result_t w;
      px = int'(f.pupil_x);
      py = int'(f.pupil_y);
      cx = int'(center_x);
      cy = int'(center_y);
      gx = int'($signed(f.gaze_x));
      gy = int'($signed(f.gaze_y));

      if (f.eye_open) begin
        closed_cnt = '0;
      end else if (closed_cnt != '1) begin
        closed_cnt = closed_cnt + ggcd_pkg::CLOSED_W'(1);
      end

      if (closed_cnt == dwell + ggcd_pkg::TOGGLE_EXTRA) begin
        if (!ctrl_on) begin
          ctrl_on = 1'b1;
          pending = ggcd_pkg::CMD_ON;
        end else begin
          ctrl_on = 1'b0;
          clear_window();
          pending = ggcd_pkg::CMD_OFF;
        end
        closed_cnt = '0;
      end

      if (!f.eye_open) return;

      if (ctrl_on) begin
        if (px < cx - ggcd_pkg::MARGIN_X) left_t  = bump(left_t);
        if (px > cx + ggcd_pkg::MARGIN_X) right_t = bump(right_t);
        if (py < cy - ggcd_pkg::MARGIN_Y) up_t    = bump(up_t);
        if (py > cy + ggcd_pkg::MARGIN_Y) down_t  = bump(down_t);
        keep = keep + 8'd1;
      end

      if (keep == dwell) begin
        l = left_t >= vote;
        r = right_t >= vote;
        u = up_t >= vote;
        d = down_t >= vote;
        if (l && u)      pending = ggcd_pkg::CMD_UP_LEFT;
        else if (r && u) pending = ggcd_pkg::CMD_UP_RIGHT;
        else if (l && d) pending = ggcd_pkg::CMD_DOWN_LEFT;
        else if (r && d) pending = ggcd_pkg::CMD_DOWN_RIGHT;
        clear_window();
      end

      ox = (gx < 0 || gx > ggcd_pkg::FRAME_WIDTH_DEF - 1) ? ggcd_pkg::FRAME_WIDTH_DEF - 1 : gx;
      oy = (gy < 0 || gy > ggcd_pkg::FRAME_HEIGHT_DEF - 1) ? ggcd_pkg::FRAME_HEIGHT_DEF - 1 : gy;
      w.out_x       = 10'(ox);
      w.out_y       = 9'(oy);
      w.command     = pending;
      w.packed_word = 23'(ox * ggcd_pkg::PACK_X + oy * ggcd_pkg::PACK_Y + int'(pending));
      expected_words = {expected_words, w};
      pending = ggcd_pkg::CMD_NONE;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word with nothing owed: x=%0d y=%0d cmd=%0d packed=%0d",
                                  got.out_x, got.out_y, got.command, got.packed_word));
        return;
      end
      want = expected_words.pop_front();
      if (got.out_x !== want.out_x)
        report_mismatch($sformatf("out_x %0d, want %0d", got.out_x, want.out_x));
      if (got.out_y !== want.out_y)
        report_mismatch($sformatf("out_y %0d, want %0d", got.out_y, want.out_y));
      if (got.command !== want.command)
        report_mismatch($sformatf("command %0d, want %0d", got.command, want.command));
      if (got.packed_word !== want.packed_word)
        report_mismatch($sformatf("packed_word %0d, want %0d", got.packed_word,
                                  want.packed_word));
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             wr_en;
  logic [ggcd_pkg::CFG_INDEX_W-1:0] wr_index;
  logic [ggcd_pkg::CFG_DATA_W-1:0]  wr_data;

  ggcd_frame_if  frame_if();
  ggcd_result_if result_if();

  gaze_command_scoreboard sb = new();

  // idle percentages per side, changed between phases
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  // long receiver hold-off: main asks, the receiver process serves
  int hold_asked  = 0;
  int hold_served = 0;
  int hold_left   = 0;
  // frame words accepted so far, used to size the random phases
  int frames_sent = 0;

  gaze_gesture_command_detector_top u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .frame    (frame_if.sink),
    .result   (result_if.source)
  );

  always #2 clk = ~clk;

  // receiver side: random stalls, or a counted hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_served + 1;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // monitor: every accepted frame word feeds the predictor, every accepted result is checked
  always @(posedge clk) begin : monitor
    frame_t  seen_frame;
    result_t seen_word;
    if (!rst) begin
      if (frame_if.valid && frame_if.ready) begin
        seen_frame.eye_open = frame_if.eye_open;
        seen_frame.pupil_x  = frame_if.pupil_x;
        seen_frame.pupil_y  = frame_if.pupil_y;
        seen_frame.gaze_x   = frame_if.gaze_x;
        seen_frame.gaze_y   = frame_if.gaze_y;
        sb.take_frame(seen_frame);
      end
      if (result_if.valid && result_if.ready) begin
        seen_word.out_x       = result_if.out_x;
        seen_word.out_y       = result_if.out_y;
        seen_word.command     = result_if.command;
        seen_word.packed_word = result_if.packed_word;
        sb.check_word(seen_word);
      end
    end
  end

  // hard stop in case the block hangs
  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic frame_t mk(bit open, int px, int py, int gx, int gy);
    frame_t f;
    f.eye_open = open;
    f.pupil_x  = 10'(px);
    f.pupil_y  = 10'(py);
    f.gaze_x   = 16'(gx);
    f.gaze_y   = 16'(gy);
    return f;
  endfunction

  // gaze is either near the frame (mostly inside, some just past the clamp) or any 16-bit value
  function automatic frame_t random_frame(bit open);
    frame_t f;
    f.eye_open = open;
    f.pupil_x  = 10'($urandom);
    f.pupil_y  = 10'($urandom);
    if ($urandom_range(1, 0)) begin
      f.gaze_x = 16'($urandom_range(660, 0));
      f.gaze_y = 16'($urandom_range(500, 0));
    end else begin
      f.gaze_x = 16'($urandom);
      f.gaze_y = 16'($urandom);
    end
    return f;
  endfunction

  // pupil coordinate just beyond the margin on one side, sometimes exactly on it
  function automatic int near(int c, int m, bit high, int top);
    int lo, hi;
    if (high) begin
      lo = c + m;
      hi = c + m + 20;
    end else begin
      lo = c - m - 20;
      hi = c - m;
    end
    if (lo < 0) lo = 0;
    if (hi > top) hi = top;
    if (lo > hi) return $urandom_range(top, 0);
    return $urandom_range(hi, lo);
  endfunction

  // offer one frame word, with an optional gap first, and hold it until taken
  task send_frame(input frame_t f);
    int gap;
    gap = ($urandom_range(99, 0) < tx_idle_pct) ? $urandom_range(4, 1) : 0;
    if (gap != 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_if.valid    <= 1'b1;
    frame_if.eye_open <= f.eye_open;
    frame_if.pupil_x  <= f.pupil_x;
    frame_if.pupil_y  <= f.pupil_y;
    frame_if.gaze_x   <= f.gaze_x;
    frame_if.gaze_y   <= f.gaze_y;
    @(posedge clk);
    while (!frame_if.ready) @(posedge clk);
    frames_sent++;
  endtask

  task send_closed(int n);
    repeat (n) send_frame(random_frame(1'b0));
  endtask

  // a gesture window: most frames look toward one corner
  task send_window(int corner, int n);
    frame_t f;
    repeat (n) begin
      f = random_frame(1'b1);
      if ($urandom_range(9, 0) < 8) begin
        f.pupil_x = 10'(near(int'(sb.center_x), ggcd_pkg::MARGIN_X, corner[0], 1023));
        f.pupil_y = 10'(near(int'(sb.center_y), ggcd_pkg::MARGIN_Y, corner[1], 1023));
      end
      send_frame(f);
    end
  endtask

  // stop offering, wait for every owed word, then let a closed frame in flight settle
  task drain();
    frame_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_reg(logic [ggcd_pkg::CFG_INDEX_W-1:0] idx, logic [ggcd_pkg::CFG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task set_config(logic [ggcd_pkg::CFG_DATA_W-1:0] cx, logic [ggcd_pkg::CFG_DATA_W-1:0] cy,
                  logic [ggcd_pkg::CFG_DATA_W-1:0] dw, logic [ggcd_pkg::CFG_DATA_W-1:0] vt,
                  bit poke_unused);
    drain();
    write_reg(ggcd_pkg::REG_CENTER_X, cx);
    write_reg(ggcd_pkg::REG_CENTER_Y, cy);
    write_reg(ggcd_pkg::REG_DWELL_FRAMES, dw);
    write_reg(ggcd_pkg::REG_VOTE_FRAMES, vt);
    if (poke_unused) write_reg(REG_NONE, 10'($urandom));
    wr_en <= 1'b0;
  endtask

  // random phase: mostly clean toggles and corner windows, plus blinks and noise frames
  task run_random(int n, bit hold_mid, bit pause_mid);
    int stop_at, half, kind, win_len, toggle_len;
    bit half_done;
    stop_at   = frames_sent + n;
    half      = frames_sent + n / 2;
    half_done = 1'b0;
    while (frames_sent < stop_at) begin
      if (!half_done && frames_sent >= half) begin
        half_done = 1'b1;
        if (hold_mid) hold_asked++;
        if (pause_mid) drain();
      end
      kind       = $urandom_range(99, 0);
      win_len    = (sb.dwell == 0) ? 12 : int'(sb.dwell);
      toggle_len = int'(sb.dwell) + ggcd_pkg::TOGGLE_EXTRA;
      if (kind < 18) begin
        send_closed(toggle_len);
      end else if (kind < 26) begin
        // two toggles back to back, the second command replaces the first
        send_closed(2 * toggle_len);
      end else if (kind < 34) begin
        // blink too short to toggle
        send_closed($urandom_range(toggle_len - 1, 1));
      end else if (kind < 80) begin
        if (!sb.ctrl_on) send_closed(toggle_len);
        send_window($urandom_range(3, 0), win_len);
      end else begin
        repeat ($urandom_range(6, 1)) send_frame(random_frame(1'($urandom_range(1, 0))));
      end
    end
  endtask

  initial begin
    bit ctrl_was_on;

    frame_if.valid    <= 1'b0;
    frame_if.eye_open <= 1'b0;
    frame_if.pupil_x  <= '0;
    frame_if.pupil_y  <= '0;
    frame_if.gaze_x   <= '0;
    frame_if.gaze_y   <= '0;
    wr_en             <= 1'b0;
    wr_index          <= '0;
    wr_data           <= '0;
    rst               <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver stalls often
    tx_idle_pct = 16;
    rx_idle_pct = 66;

    // gaze clamp edges with control off and the reset configuration
    send_frame(mk(1, 0, 0, 0, 0));
    send_frame(mk(1, 1023, 1023, 639, 479));
    send_frame(mk(1, 512, 511, 640, 480));
    send_frame(mk(1, 1, 2, -1, -1));
    send_frame(mk(1, 700, 300, -32768, 32767));
    send_frame(mk(1, 300, 700, 32767, -32768));

    // one-frame windows, vote of one; dwell written with junk above its width,
    // and a write to an unused index
    set_config(320, 240, 10'h301, 1, 1'b1);
    send_closed(11);                            // control on, command pending
    send_frame(mk(1, 320, 240, 100, 100));      // window ends with no vote, on is kept
    send_frame(mk(1, 0, 0, 10, 20));            // up-left
    send_frame(mk(1, 1023, 0, 30, 40));         // up-right
    send_frame(mk(1, 0, 1023, 50, 60));         // down-left
    send_frame(mk(1, 1023, 1023, 70, 80));      // down-right
    send_frame(mk(1, 315, 237, 90, 100));       // exactly on the low margins, no tally
    send_frame(mk(1, 325, 243, 110, 120));      // exactly on the high margins, no tally
    send_closed(11);                            // control off
    send_frame(mk(1, 320, 240, 5, 5));

    // random phases under the first idling mix, with a long hold-off and a full pause
    set_config(320, 240, 4, 2, 1'b0);
    run_random(90, 1'b1, 1'b0);
    set_config(0, 0, 3, 0, 1'b0);
    run_random(70, 1'b0, 1'b1);
    // largest dwell: stop one closed frame short of a toggle past the 8-bit range,
    // leaving a closed count that the next, shorter dwell can never match
    set_config(639, 479, 255, 255, 1'b0);
    send_frame(random_frame(1'b1));
    send_closed(264);

    // swap the idling mix
    tx_idle_pct = 66;
    rx_idle_pct = 16;

    // closed count runs into its ceiling and stays there
    set_config(1023, 511, 5, 3, 1'b0);
    send_closed(250);
    run_random(30, 1'b0, 1'b0);

    // control on under the short dwell, then a long window cut short by a smaller dwell:
    // keep wraps, tallies saturate
    ctrl_was_on = sb.ctrl_on;
    send_frame(mk(1, 320, 240, 200, 200));
    if (!ctrl_was_on) send_closed(int'(sb.dwell) + ggcd_pkg::TOGGLE_EXTRA);
    set_config(320, 240, 200, 255, 1'b0);
    repeat (150) send_frame(mk(1, 0, 0, $urandom_range(700, 0), $urandom_range(500, 0)));
    set_config(320, 240, 20, 255, 1'b0);
    repeat (130) send_frame(mk(1, 0, 0, $urandom_range(700, 0), $urandom_range(500, 0)));

    // zero dwell, written with junk in the upper bits
    set_config(320, 240, 10'h300, 0, 1'b0);
    run_random(40, 1'b0, 1'b0);

    // no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(5, 3, 2, 1, 1'b0);
    run_random(40, 1'b0, 1'b0);
    set_config(10'($urandom), 10'($urandom_range(511, 0)),
               10'(($urandom_range(3, 0) << 8) | $urandom_range(8, 1)),
               10'($urandom_range(4, 0)), 1'b1);
    run_random(40, 1'b0, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
